[hdl/rotation_matrix_to_euler_macros.svh]
// Assertion macros for the rotation matrix to Euler angle top level.
`ifndef ROTATION_MATRIX_TO_EULER_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RME_ASSERT_IMPL(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RME_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

[hdl/rme_pkg.sv]
// Types and constants of the rotation matrix to Euler angle pipeline.
package rme_pkg;

    localparam int VEC_W = 46;
    localparam int ANG_W = 28;
    localparam int MAX_STEPS = 24;

    localparam logic signed [ANG_W-1:0] HALF_PI = 28'sd26353589;
    localparam logic signed [15:0] OUT_PI = 16'sd25736;

    // atan(2^-i) in units of 2^-24 rad
    localparam logic signed [ANG_W-1:0] ATAN_TAB [MAX_STEPS] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214, 28'sd524117, 28'sd262123, 28'sd131069,
        28'sd65536, 28'sd32768, 28'sd16384, 28'sd8192,
        28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
        28'sd256, 28'sd128, 28'sd64, 28'sd32,
        28'sd16, 28'sd8, 28'sd4, 28'sd2
    };

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } rme_vec_t;

    typedef struct packed {
        logic [31:0] rad;
        logic [18:0] rem;
        logic [15:0] root;
    } rme_sqrt_t;

    typedef struct packed {
        logic signed [15:0] m02;
        logic signed [15:0] m12;
        logic signed [15:0] m22;
        logic signed [32:0] yaw_y;
        logic signed [32:0] yaw_x;
    } rme_side_t;

endpackage

[hdl/rme_in_if.sv]
// Input channel: one rotation matrix word.
interface rme_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] elem_00;
    logic signed [15:0] elem_01;
    logic signed [15:0] elem_02;
    logic signed [15:0] elem_10;
    logic signed [15:0] elem_11;
    logic signed [15:0] elem_12;
    logic signed [15:0] elem_20;
    logic signed [15:0] elem_21;
    logic signed [15:0] elem_22;

    modport source (
        output valid, elem_00, elem_01, elem_02, elem_10, elem_11, elem_12,
               elem_20, elem_21, elem_22,
        input  ready
    );
    modport sink (
        input  valid, elem_00, elem_01, elem_02, elem_10, elem_11, elem_12,
               elem_20, elem_21, elem_22,
        output ready
    );
endinterface

[hdl/rme_out_if.sv]
// Output channel: one roll, pitch, yaw word.
interface rme_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;

    modport source (
        output valid, roll_angle, pitch_angle, yaw_angle,
        input  ready
    );
    modport sink (
        input  valid, roll_angle, pitch_angle, yaw_angle,
        output ready
    );
endinterface

[hdl/rme_sqrt_cell.sv]
// One cell of the integer square root chain: resolves one root bit.
module rme_sqrt_cell (
    input  logic                clk,
    input  logic                en,
    input  rme_pkg::rme_sqrt_t  d,
    output rme_pkg::rme_sqrt_t  q
);
    import rme_pkg::*;

    rme_sqrt_t   sq_reg;
    rme_sqrt_t   sq_next;
    logic [18:0] cand;
    logic [18:0] trial;
    logic        ge;

    always_comb
    begin
        cand  = {d.rem[16:0], d.rad[31:30]};
        trial = {1'b0, d.root, 2'b01};
        ge    = (cand >= trial);
        sq_next.rad  = {d.rad[29:0], 2'b00};
        sq_next.rem  = ge ? (cand - trial) : cand;
        sq_next.root = {d.root[14:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_next;
        end
    end

    assign q = sq_reg;
endmodule

[hdl/rme_cordic_cell.sv]
// One vectoring CORDIC micro-rotation cell with a fixed shift.
module rme_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic               clk,
    input  logic               en,
    input  rme_pkg::rme_vec_t  d,
    output rme_pkg::rme_vec_t  q
);
    import rme_pkg::*;

    rme_vec_t                vec_reg;
    rme_vec_t                vec_next;
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;

    always_comb
    begin
        xs = d.x >>> STEP;
        ys = d.y >>> STEP;
        vec_next.zero = d.zero;
        if (!d.y[VEC_W-1])
        begin
            vec_next.x = d.x + ys;
            vec_next.y = d.y - xs;
            vec_next.z = d.z + ATAN_TAB[STEP];
        end
        else
        begin
            vec_next.x = d.x - ys;
            vec_next.y = d.y + xs;
            vec_next.z = d.z - ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    assign q = vec_reg;
endmodule

[hdl/rotation_matrix_to_euler.sv]
// Top level: rotation matrix to roll, pitch and yaw through a chain of cells.
// Throughput: one word per cycle while ang_out.ready holds; every stage is a register, no shared unit.
// Each stage holds its word only while the stage behind it is full and
// stalled, so bubbles close up and input is taken while a result waits.
// Reset (rst_n, async, low) clears all stage valid bits; payload is not reset.
module rotation_matrix_to_euler #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rme_in_if.sink    mat_in,
    rme_out_if.source ang_out
);
    import rme_pkg::*;
    `include "rotation_matrix_to_euler_macros.svh"

    localparam int NSTEP    = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
    localparam int SQ_CELLS = 16;
    localparam int ST_PROD  = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_SQ    = 3;
    localparam int ST_SETUP = ST_SQ + SQ_CELLS;
    localparam int ST_CORD  = ST_SETUP + 1;
    localparam int ST_LAST  = ST_CORD + NSTEP;
    localparam int NSTG     = ST_LAST + 1;

    // Stage valid bits and per-stage advance enables
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;

    genvar k;
    generate
        for (k = 0; k < NSTG; k++)
        begin : g_en
            if (k == NSTG - 1)
            begin : g_tail
                assign en[k] = !vld_reg[k] || ang_out.ready;
            end
            else
            begin : g_body
                assign en[k] = !vld_reg[k] || en[k+1];
            end
        end
    endgenerate

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = mat_in.valid;
        end
        for (int i = 1; i < NSTG; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign mat_in.ready  = en[0];
    assign ang_out.valid = vld_reg[ST_LAST];

    // Stage 0: capture the matrix
    logic signed [15:0] m00_reg, m01_reg, m02_reg, m10_reg, m11_reg;
    logic signed [15:0] m12_reg, m20_reg, m21_reg, m22_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            m00_reg <= mat_in.elem_00;
            m01_reg <= mat_in.elem_01;
            m02_reg <= mat_in.elem_02;
            m10_reg <= mat_in.elem_10;
            m11_reg <= mat_in.elem_11;
            m12_reg <= mat_in.elem_12;
            m20_reg <= mat_in.elem_20;
            m21_reg <= mat_in.elem_21;
            m22_reg <= mat_in.elem_22;
        end
    end

    // Stage 1: products. Roll's sine and cosine stand in as m12 and m22
    // (same positive scale); a zero roll vector falls back to s = 0, c = 1.
    logic signed [15:0] s_val;
    logic signed [15:0] c_val;
    logic signed [31:0] sq0_reg, sq1_reg;
    logic signed [31:0] sm20_reg, cm10_reg, cm11_reg, sm21_reg;
    logic signed [15:0] p_m02_reg, p_m12_reg, p_m22_reg;

    always_comb
    begin
        if (m12_reg == '0 && m22_reg == '0)
        begin
            s_val = 16'sd0;
            c_val = 16'sd16384;
        end
        else
        begin
            s_val = m12_reg;
            c_val = m22_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            sq0_reg   <= m00_reg * m00_reg;
            sq1_reg   <= m01_reg * m01_reg;
            sm20_reg  <= s_val * m20_reg;
            cm10_reg  <= c_val * m10_reg;
            cm11_reg  <= c_val * m11_reg;
            sm21_reg  <= s_val * m21_reg;
            p_m02_reg <= m02_reg;
            p_m12_reg <= m12_reg;
            p_m22_reg <= m22_reg;
        end
    end

    // Stage 2: sum of squares for pitch, yaw operand differences
    rme_sqrt_t sq_init_reg;
    rme_side_t side_reg [SQ_CELLS+1];

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            sq_init_reg.rad     <= $unsigned(sq0_reg) + $unsigned(sq1_reg);
            sq_init_reg.rem     <= '0;
            sq_init_reg.root    <= '0;
            side_reg[0].m02     <= p_m02_reg;
            side_reg[0].m12     <= p_m12_reg;
            side_reg[0].m22     <= p_m22_reg;
            side_reg[0].yaw_y   <= 33'(sm20_reg) - 33'(cm10_reg);
            side_reg[0].yaw_x   <= 33'(cm11_reg) - 33'(sm21_reg);
        end
    end

    // Stages 3..18: square root chain, side data delayed alongside
    rme_sqrt_t sq_chain [SQ_CELLS];

    generate
        for (k = 0; k < SQ_CELLS; k++)
        begin : g_sqrt
            if (k == 0)
            begin : g_first
                rme_sqrt_cell u_cell (
                    .clk (clk),
                    .en  (en[ST_SQ+k]),
                    .d   (sq_init_reg),
                    .q   (sq_chain[k])
                );
            end
            else
            begin : g_next
                rme_sqrt_cell u_cell (
                    .clk (clk),
                    .en  (en[ST_SQ+k]),
                    .d   (sq_chain[k-1]),
                    .q   (sq_chain[k])
                );
            end

            always_ff @(posedge clk)
            begin
                if (en[ST_SQ+k])
                begin
                    side_reg[k+1] <= side_reg[k];
                end
            end
        end
    endgenerate

    // Stage 19: CORDIC setup. Turn a left-half vector by 90 degrees and
    // preload the angle; flag the all-zero vector.
    function automatic rme_vec_t cordic_pre(logic signed [VEC_W-1:0] y,
                                            logic signed [VEC_W-1:0] x);
        rme_vec_t v;
        v.zero = (x == '0) && (y == '0);
        v.x    = x;
        v.y    = y;
        v.z    = '0;
        if (x[VEC_W-1])
        begin
            if (!y[VEC_W-1])
            begin
                v.x = y;
                v.y = -x;
                v.z = HALF_PI;
            end
            else
            begin
                v.x = -y;
                v.y = x;
                v.z = -HALF_PI;
            end
        end
        return v;
    endfunction

    rme_side_t               sd;
    logic signed [VEC_W-1:0] pitch_x;
    rme_vec_t                setup_reg [3];

    always_comb
    begin
        sd      = side_reg[SQ_CELLS];
        pitch_x = $signed(VEC_W'(sq_chain[SQ_CELLS-1].root));
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SETUP])
        begin
            setup_reg[0] <= cordic_pre(VEC_W'(sd.m12) <<< 24, VEC_W'(sd.m22) <<< 24);
            setup_reg[1] <= cordic_pre(-(VEC_W'(sd.m02)) <<< 24, pitch_x <<< 24);
            setup_reg[2] <= cordic_pre(VEC_W'(sd.yaw_y) <<< 9, VEC_W'(sd.yaw_x) <<< 9);
        end
    end

    // CORDIC chain: three lanes (roll, pitch, yaw), one cell per iteration
    rme_vec_t cord [3][NSTEP];

    genvar ln;
    generate
        for (ln = 0; ln < 3; ln++)
        begin : g_lane
            for (k = 0; k < NSTEP; k++)
            begin : g_step
                if (k == 0)
                begin : g_first
                    rme_cordic_cell #(.STEP(k)) u_cell (
                        .clk (clk),
                        .en  (en[ST_CORD+k]),
                        .d   (setup_reg[ln]),
                        .q   (cord[ln][k])
                    );
                end
                else
                begin : g_next
                    rme_cordic_cell #(.STEP(k)) u_cell (
                        .clk (clk),
                        .en  (en[ST_CORD+k]),
                        .d   (cord[ln][k-1]),
                        .q   (cord[ln][k])
                    );
                end
            end
        end
    endgenerate

    // Last stage: round half up to Q2.13 and clamp to +/- pi; an all-zero vector gives 0
    function automatic logic signed [15:0] finish(rme_vec_t v);
        logic signed [ANG_W:0] zs;
        logic signed [ANG_W:0] zt;
        logic signed [15:0]    r;
        zs = $signed({v.z[ANG_W-1], v.z}) + $signed((ANG_W+1)'(1024));
        zt = zs >>> 11;
        if (v.zero)
        begin
            r = '0;
        end
        else if (zt > $signed((ANG_W+1)'(OUT_PI)))
        begin
            r = OUT_PI;
        end
        else if (zt < -$signed((ANG_W+1)'(OUT_PI)))
        begin
            r = -OUT_PI;
        end
        else
        begin
            r = zt[15:0];
        end
        return r;
    endfunction

    logic signed [15:0] ang_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[ST_LAST])
        begin
            for (int i = 0; i < 3; i++)
            begin
                ang_reg[i] <= finish(cord[i][NSTEP-1]);
            end
        end
    end

    assign ang_out.roll_angle  = ang_reg[0];
    assign ang_out.pitch_angle = ang_reg[1];
    assign ang_out.yaw_angle   = ang_reg[2];

    // An empty entry stage always takes a word
    `RME_ASSERT_IMPL(a_ready_empty, !vld_reg[0], mat_in.ready, "entry stage empty but not ready")
    `RME_ASSERT_NEXT(a_fill_entry, !vld_reg[0] && mat_in.valid, vld_reg[0], "offered word was dropped")
    `RME_ASSERT_IMPL(a_roll_range, ang_out.valid, ang_reg[0] <= OUT_PI && ang_reg[0] >= -OUT_PI, "roll beyond pi")
    `RME_ASSERT_IMPL(a_pitch_range, ang_out.valid, ang_reg[1] <= OUT_PI && ang_reg[1] >= -OUT_PI, "pitch beyond pi")
    `RME_ASSERT_IMPL(a_yaw_range, ang_out.valid, ang_reg[2] <= OUT_PI && ang_reg[2] >= -OUT_PI, "yaw beyond pi")
endmodule

[sim/rme_euler_checker.sv]
// Checker: predicts roll, pitch and yaw for each accepted matrix and compares results.
`timescale 1ns / 100ps
module rme_euler_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    rme_in_if.sink  mat_mon,
    rme_out_if.sink ang_mon,
    output int      fail_count,
    output int      pending_count
);
    import rme_pkg::*;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } angles_t;

    angles_t expected_angles [$];

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(longint v);
        longint res;
        longint bitv;
        res = 0;
        bitv = 64'd1 << 30;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] vector_angle(longint y, longint x);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0)
            return 16'sd0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = HALF_PI;
            end
            else
            begin
                x = -y; y = t; z = -longint'(HALF_PI);
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < MAX_STEPS; i++)
        begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end
            else
            begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end
        end
        z = floor_shr(z + 1024, 11);
        if (z > OUT_PI)
            z = OUT_PI;
        if (z < -longint'(OUT_PI))
            z = -longint'(OUT_PI);
        return z[15:0];
    endfunction

    function automatic angles_t predict_angles(
        longint m00, longint m01, longint m02, longint m10, longint m11,
        longint m12, longint m20, longint m21, longint m22);
        angles_t a;
        longint r;
        longint s;
        longint c;
        a.roll = vector_angle(m12 <<< 24, m22 <<< 24);
        r = isqrt((m00 * m00 + m01 * m01) & 64'hFFFF_FFFF);
        a.pitch = vector_angle((-m02) <<< 24, r <<< 24);
        if (m12 == 0 && m22 == 0)
        begin
            s = 0; c = 16384;
        end
        else
        begin
            s = m12; c = m22;
        end
        a.yaw = vector_angle((s * m20 - c * m10) <<< 9, (c * m11 - s * m21) <<< 9);
        return a;
    endfunction

    assign pending_count = expected_angles.size();

    always @(posedge clk)
    begin
        angles_t got;
        angles_t want;
        if (rst_n)
        begin
            if (mat_mon.valid && mat_mon.ready)
                expected_angles.push_back(predict_angles(
                    mat_mon.elem_00, mat_mon.elem_01, mat_mon.elem_02,
                    mat_mon.elem_10, mat_mon.elem_11, mat_mon.elem_12,
                    mat_mon.elem_20, mat_mon.elem_21, mat_mon.elem_22));
            if (ang_mon.valid && ang_mon.ready)
            begin
                got = {ang_mon.roll_angle, ang_mon.pitch_angle, ang_mon.yaw_angle};
                if (expected_angles.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %0d %0d %0d",
                                 got.roll, got.pitch, got.yaw);
                end
                else
                begin
                    want = expected_angles.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch roll %0d/%0d pitch %0d/%0d yaw %0d/%0d",
                                     want.roll, got.roll, want.pitch, got.pitch,
                                     want.yaw, got.yaw);
                    end
                end
            end
        end
    end

    initial fail_count = 0;
endmodule

[sim/tb_top.sv]
// Testbench top: drives matrices into the block, stalls the output and gives the verdict.
`timescale 1ns / 100ps
module tb_top;
    localparam int STEPS = 16;
    localparam int LATENCY = STEPS + 20;
    localparam int RANDOM_WORDS = 1900;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count;
    logic quiet;

    rme_in_if  mat_in ();
    rme_out_if ang_out ();

    rotation_matrix_to_euler #(.CORDIC_STEPS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n), .mat_in(mat_in.sink), .ang_out(ang_out.source)
    );

    rme_euler_checker #(.CORDIC_STEPS(STEPS)) checker_inst (
        .clk(clk), .rst_n(rst_n), .mat_mon(mat_in.sink), .ang_mon(ang_out.sink),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Count cycles and end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stall the receiver at random with a chance of 8 in 100, never in the quiet stretch.
    always @(posedge clk)
        ang_out.ready <= quiet || ($urandom_range(99) >= 8);

    // Pick a random element, biased toward the extremes and a unit scale.
    function automatic logic [15:0] rand_elem();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            4: return 16'($urandom_range(64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Drive one word and hold it until accepted; idle first at random.
    task automatic send_word(input logic [15:0] e [9]);
        if (!quiet)
            while ($urandom_range(99) < 8)
            begin
                mat_in.valid <= 1'b0;
                @(posedge clk);
            end
        mat_in.valid   <= 1'b1;
        mat_in.elem_00 <= e[0]; mat_in.elem_01 <= e[1]; mat_in.elem_02 <= e[2];
        mat_in.elem_10 <= e[3]; mat_in.elem_11 <= e[4]; mat_in.elem_12 <= e[5];
        mat_in.elem_20 <= e[6]; mat_in.elem_21 <= e[7]; mat_in.elem_22 <= e[8];
        do
            @(posedge clk);
        while (!mat_in.ready);
    endtask

    // Build a rotation about one axis from a cosine and sine pair.
    task automatic send_rotation(input int ax, input logic [15:0] c,
                                 input logic [15:0] s);
        logic [15:0] e [9];
        for (int k = 0; k < 9; k++)
            e[k] = 16'h0000;
        e[0] = 16'sd16384; e[4] = 16'sd16384; e[8] = 16'sd16384;
        case (ax)
            0: begin e[4] = c; e[8] = c; e[5] = -s; e[7] = s; end
            1: begin e[0] = c; e[8] = c; e[2] = s; e[6] = -s; end
            default: begin e[0] = c; e[4] = c; e[1] = -s; e[3] = s; end
        endcase
        send_word(e);
    endtask

    initial
    begin
        logic [15:0] e [9];
        real ang;
        cycle_count    = 0;
        quiet          = 1'b0;
        rst_n          = 1'b0;
        mat_in.valid   = 1'b0;
        ang_out.ready  = 1'b0;
        mat_in.elem_00 = '0; mat_in.elem_01 = '0; mat_in.elem_02 = '0;
        mat_in.elem_10 = '0; mat_in.elem_11 = '0; mat_in.elem_12 = '0;
        mat_in.elem_20 = '0; mat_in.elem_21 = '0; mat_in.elem_22 = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, all zero (every atan2 at the origin), extremes.
        send_rotation(0, 16'sd16384, 16'sd0);
        for (int k = 0; k < 9; k++) e[k] = 16'h0000;
        send_word(e);
        for (int k = 0; k < 9; k++) e[k] = 16'h7FFF;
        send_word(e);
        for (int k = 0; k < 9; k++) e[k] = 16'h8000;
        send_word(e);
        for (int k = 0; k < 9; k++) e[k] = k[0] ? 16'h8000 : 16'h7FFF;
        send_word(e);
        // Roll near plus and minus pi, gimbal lock, negative x quadrants.
        send_rotation(0, -16'sd16384, 16'sd0);
        send_rotation(0, -16'sd16384, -16'sd1);
        send_rotation(0, -16'sd16384, 16'sd1);
        send_rotation(1, 16'sd0, 16'sd16384);
        send_rotation(1, 16'sd0, -16'sd16384);
        send_rotation(2, -16'sd16384, 16'sd0);
        send_rotation(2, -16'sd16384, -16'sd1);
        send_rotation(2, 16'sd0, -16'sd16384);
        // Roll row zero so yaw falls back to s = 0, c = 1.
        for (int k = 0; k < 9; k++) e[k] = 16'h0000;
        e[3] = 16'sd11585; e[4] = -16'sd11585; e[0] = 16'sd16384;
        send_word(e);

        // Random: mostly real rotations, the rest raw noise.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            quiet = (n >= 600 && n < 900);
            if ($urandom_range(9) < 6)
            begin
                ang = ($urandom_range(20000) / 10000.0 - 1.0) * 3.14159265;
                send_rotation($urandom_range(2), 16'($rtoi($cos(ang) * 16384.0)),
                              16'($rtoi($sin(ang) * 16384.0)));
            end
            else
            begin
                for (int k = 0; k < 9; k++) e[k] = rand_elem();
                send_word(e);
            end
        end
        mat_in.valid <= 1'b0;

        // Drain, then let the pipeline settle.
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
